[hdl/iee_pkg.sv]
// shared types and constants for the infix expression evaluator
// used by the front end, the reduction unit and the top level
package iee_pkg;

  localparam int unsigned DefOperandDepth = 4;
  localparam int unsigned DefFracBits     = 32;
  localparam int unsigned ValW            = 64;
  localparam int unsigned QueueDepth      = 2;

  typedef enum logic [1:0] {
    TOK_OPERAND  = 2'd0,
    TOK_OPERATOR = 2'd1,
    TOK_EQUALS   = 2'd2,
    TOK_CLEAR    = 2'd3
  } tok_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ERR_OK    = 3'd0,
    ERR_DIV0  = 3'd1,
    ERR_SAT   = 3'd2,
    ERR_UNDER = 3'd3,
    ERR_OVER  = 3'd4
  } err_t;

  // classified token as it travels from the front end to the back end
  typedef struct packed {
    tok_t              kind;
    op_t               op;
    logic [ValW-1:0]   value;
  } tok_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RED_START,
    ST_RED_READ,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_DIV_RUN,
    ST_FINISH,
    ST_EMIT
  } st_t;

endpackage

[hdl/infix_expression_evaluator.sv]
// Infix expression evaluator, two precedence levels, signed fixed point.
// Input stream: one token per transaction, its kind on in_tuser. A token is
// an operand (pushed), an operator (pending operators of equal or higher
// precedence are reduced first), equals (all reduced, the top of the operand
// stack is sent on the output stream and stays for chaining) or clear.
// Output stream: one transaction per equals, value and sticky error code.
// An add or subtract reduction passes through start, read and finish; a
// multiply also through the multiplier states (four registered 32x32 partial
// products); a divide runs the 128-step restoring divider that produces one
// quotient bit per cycle. One token may cause two reductions, so a token
// can hold the back end through both; tokens are handled one at a time
// and a two-entry token queue lets the front accept meanwhile.
// Reset (rst_n low, synchronous) empties both stacks and clears the error.
// If the receiver stalls, the result is held in the output register; a
// further equals waits for it, which holds back every token behind it.
// Depends on iee_pkg, iee_front and iee_back.
module infix_expression_evaluator
  import iee_pkg::*;
#(
  parameter int unsigned OPERAND_DEPTH = DefOperandDepth,
  parameter int unsigned FRAC_BITS     = DefFracBits
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  input  logic [71:0] in_tdata,   // operand_value[63:0], operator_code[65:64]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // result_value[63:0], error_status[66:64]
);

  logic             q_valid, q_pop;
  tok_item_t        q_item;
  logic [ValW-1:0]  res_value;
  logic [2:0]       res_err;
  logic             unused_pad;

  assign unused_pad = ^in_tdata[71:66];

  iee_front u_front (
    .clk, .rst_n,
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_opcode (in_tuser),
    .in_opcode_op (in_tdata[65:64]),
    .in_value (in_tdata[63:0]),
    .q_valid, .q_pop, .q_item
  );

  iee_back #(.OPERAND_DEPTH(OPERAND_DEPTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_item,
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_value, .res_err
  );

  assign out_tdata = {5'b0 | {4'b0, unused_pad & 1'b0}, res_err, res_value};

endmodule

[hdl/iee_front.sv]
// front end: accepts input transactions, classifies the token and queues it
// depends on iee_pkg
module iee_front
  import iee_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_opcode,
  input  logic [1:0]        in_opcode_op,
  input  logic [ValW-1:0]   in_value,
  output logic              q_valid,
  input  logic              q_pop,
  output tok_item_t         q_item
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  tok_item_t          mem_r [QueueDepth];
  logic [PtrW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PtrW:0]      cnt_r, cnt_nxt;
  logic               push;
  tok_item_t          new_item;

  assign in_ready = (cnt_r != (PtrW+1)'(QueueDepth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    new_item.kind  = tok_t'(in_opcode);
    new_item.op    = op_t'(in_opcode_op);
    // operand value only matters for operand tokens
    new_item.value = (tok_t'(in_opcode) == TOK_OPERAND) ? in_value : '0;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = (q_pop && q_valid) ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (PtrW+1)'(push) - (PtrW+1)'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PtrW+1)'(QueueDepth))
    else $error("token queue count out of range");
  a_full_noready: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == (PtrW+1)'(QueueDepth)) |-> !in_ready)
    else $error("ready while queue full");
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not grow on push");

endmodule

[hdl/iee_back.sv]
// back end: operand and operator stacks, reduction sequencer with four 32x32
// multipliers and a restoring divider, result register; depends on iee_pkg
module iee_back
  import iee_pkg::*;
#(
  parameter int unsigned OPERAND_DEPTH = DefOperandDepth,
  parameter int unsigned FRAC_BITS     = DefFracBits
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  tok_item_t         q_item,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [ValW-1:0]   res_value,
  output logic [2:0]        res_err
);

  localparam int unsigned IdxW = $clog2(OPERAND_DEPTH);
  localparam int unsigned CntW = $clog2(OPERAND_DEPTH + 1);
  localparam int unsigned DivW = 2 * ValW;
  localparam int unsigned StepW = $clog2(DivW);
  localparam logic [ValW-1:0] SMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic [ValW-1:0] SMin = {1'b1, {(ValW-1){1'b0}}};

  logic [ValW-1:0]  stk_r [OPERAND_DEPTH];
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  op_t              ops_r [2];
  logic [1:0]       opc_r, opc_nxt;
  err_t             err_r, err_nxt;
  st_t              st_r, st_nxt;
  tok_item_t        tok_r, tok_nxt;

  logic [ValW-1:0]  a_r, a_nxt, b_r, b_nxt;
  op_t              rop_r, rop_nxt;
  logic             neg_r, neg_nxt;
  logic [ValW-1:0]  ma_r, ma_nxt, mb_r, mb_nxt;
  logic [63:0]      pp_r [4];
  logic [DivW-1:0]  prod_r, prod_nxt;
  logic [DivW-1:0]  num_r, num_nxt;
  logic [ValW:0]    rem_r, rem_nxt;
  logic [DivW-1:0]  quo_r, quo_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic [ValW-1:0]  c_r, c_nxt;
  logic             cwr_r, cwr_nxt;

  logic [ValW-1:0]  out_val_r, out_val_nxt;
  logic [2:0]       out_err_r, out_err_nxt;
  logic             out_vld_r, out_vld_nxt;

  logic             push_opd, stk_wr;
  logic [IdxW-1:0]  stk_wa;
  logic [ValW-1:0]  stk_wd;
  logic             top_low, new_low;
  op_t              top_op;
  logic [ValW-1:0]  sum, bneg;
  logic             ov;
  logic [ValW:0]    rsh;
  logic [DivW-1:0]  qsh;
  logic [DivW-1:0]  mag_q;

  assign res_valid = out_vld_r;
  assign res_value = out_val_r;
  assign res_err   = out_err_r;

  function automatic err_t flag_f(err_t cur, err_t e);
    return (cur == ERR_OK) ? e : cur;
  endfunction

  function automatic logic [ValW-1:0] mag_f(logic [ValW-1:0] x);
    return x[ValW-1] ? (~x + 1'b1) : x;
  endfunction

  always_comb begin
    top_op  = ops_r[opc_r[0] ? 1'b0 : 1'b1];
    if (opc_r == 2'd1) top_op = ops_r[0];
    top_low = (top_op == OP_ADD) || (top_op == OP_SUB);
    new_low = (tok_r.op == OP_ADD) || (tok_r.op == OP_SUB);
    bneg = (rop_r == OP_SUB) ? (~b_r + 1'b1) : b_r;
    sum  = a_r + bneg;
    ov   = (rop_r == OP_SUB)
         ? ((a_r[ValW-1] != b_r[ValW-1]) && (sum[ValW-1] != a_r[ValW-1]))
         : ((a_r[ValW-1] == b_r[ValW-1]) && (sum[ValW-1] != a_r[ValW-1]));
    rsh = {rem_r[ValW-1:0], num_r[DivW-1]};
    qsh = {quo_r[DivW-2:0], 1'b0};
    mag_q = (rop_r == OP_MUL) ? (prod_r >> FRAC_BITS) : quo_r;
  end

  always_comb begin
    st_nxt = st_r; tok_nxt = tok_r;
    cnt_nxt = cnt_r; opc_nxt = opc_r; err_nxt = err_r;
    a_nxt = a_r; b_nxt = b_r; rop_nxt = rop_r; neg_nxt = neg_r;
    ma_nxt = ma_r; mb_nxt = mb_r; prod_nxt = prod_r;
    num_nxt = num_r; rem_nxt = rem_r; quo_nxt = quo_r; step_nxt = step_r;
    c_nxt = c_r; cwr_nxt = 1'b0;
    out_val_nxt = out_val_r; out_err_nxt = out_err_r;
    out_vld_nxt = out_vld_r && !res_ready;
    q_pop = 1'b0; push_opd = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1; tok_nxt = q_item; st_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (tok_r.kind)
          TOK_OPERAND: begin
            if (cnt_r >= CntW'(OPERAND_DEPTH)) err_nxt = flag_f(err_r, ERR_OVER);
            else begin push_opd = 1'b1; cnt_nxt = cnt_r + 1'b1; end
            st_nxt = ST_IDLE;
          end
          TOK_OPERATOR: begin
            if (opc_r != 2'd0 && !(!new_low && top_low)) begin
              st_nxt = ST_RED_START;
            end else begin
              if (opc_r >= 2'd2) err_nxt = flag_f(err_r, ERR_OVER);
              else opc_nxt = opc_r + 1'b1;
              st_nxt = ST_IDLE;
            end
          end
          TOK_EQUALS: begin
            if (opc_r != 2'd0) begin
              st_nxt = ST_RED_START;
            end else if (!out_vld_r || res_ready) begin
              st_nxt = ST_EMIT;
            end
          end
          default: begin
            cnt_nxt = '0; opc_nxt = '0; err_nxt = ERR_OK; st_nxt = ST_IDLE;
          end
        endcase
      end
      ST_RED_START: begin
        opc_nxt = opc_r - 1'b1;
        rop_nxt = top_op;
        if (cnt_r < CntW'(2)) begin
          err_nxt = flag_f(err_r, ERR_UNDER);
          st_nxt = ST_FINISH;
        end else begin
          st_nxt = ST_RED_READ;
        end
      end
      ST_RED_READ: begin
        a_nxt = stk_r[IdxW'(cnt_r - CntW'(2))];
        b_nxt = stk_r[IdxW'(cnt_r - CntW'(1))];
        st_nxt = ST_MUL_A;
        if (rop_r == OP_ADD || rop_r == OP_SUB) st_nxt = ST_FINISH;
        ma_nxt = mag_f(stk_r[IdxW'(cnt_r - CntW'(2))]);
        mb_nxt = mag_f(stk_r[IdxW'(cnt_r - CntW'(1))]);
        neg_nxt = stk_r[IdxW'(cnt_r - CntW'(2))][ValW-1]
                ^ stk_r[IdxW'(cnt_r - CntW'(1))][ValW-1];
      end
      ST_MUL_A: begin
        if (rop_r == OP_MUL) st_nxt = ST_MUL_B;
        else if (b_r == '0) begin
          c_nxt = a_r[ValW-1] ? SMin : SMax;
          err_nxt = flag_f(err_r, ERR_DIV0);
          cwr_nxt = 1'b1; st_nxt = ST_FINISH;
        end else begin
          num_nxt = DivW'(ma_r) << FRAC_BITS;
          rem_nxt = '0; quo_nxt = '0; step_nxt = '0;
          st_nxt = ST_DIV_RUN;
        end
      end
      ST_MUL_B: begin
        st_nxt = ST_MUL_C;
      end
      ST_MUL_C: begin
        prod_nxt = {pp_r[3], pp_r[0]} + (DivW'(pp_r[1]) << 32)
                 + (DivW'(pp_r[2]) << 32);
        st_nxt = ST_FINISH;
        cwr_nxt = 1'b0;
      end
      ST_DIV_RUN: begin
        num_nxt = {num_r[DivW-2:0], 1'b0};
        if (rsh >= {1'b0, mb_r}) begin
          rem_nxt = rsh - {1'b0, mb_r}; quo_nxt = qsh | DivW'(1);
        end else begin
          rem_nxt = rsh; quo_nxt = qsh;
        end
        step_nxt = step_r + 1'b1;
        if (step_r == StepW'(DivW - 1)) st_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (cnt_r >= CntW'(2) && !cwr_r) begin
          if (rop_r == OP_ADD || rop_r == OP_SUB) begin
            if (ov) begin
              c_nxt = a_r[ValW-1] ? SMin : SMax; err_nxt = flag_f(err_r, ERR_SAT);
            end else c_nxt = sum;
          end else if (neg_r) begin
            if (mag_q > DivW'(SMin)) begin
              c_nxt = SMin; err_nxt = flag_f(err_r, ERR_SAT);
            end else c_nxt = ~mag_q[ValW-1:0] + 1'b1;
          end else begin
            if (mag_q > DivW'(SMax)) begin
              c_nxt = SMax; err_nxt = flag_f(err_r, ERR_SAT);
            end else c_nxt = mag_q[ValW-1:0];
          end
          cwr_nxt = 1'b1;
          st_nxt = ST_FINISH;
        end else begin
          if (cwr_r) cnt_nxt = cnt_r - 1'b1;
          st_nxt = ST_DISPATCH;
        end
      end
      ST_EMIT: begin
        out_vld_nxt = 1'b1;
        err_nxt     = (cnt_r == '0) ? flag_f(err_r, ERR_UNDER) : err_r;
        out_err_nxt = err_nxt;
        out_val_nxt = (cnt_r == '0) ? '0 : stk_r[IdxW'(cnt_r - CntW'(1))];
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // stack write port: operand push or reduction result
  always_comb begin
    stk_wr = push_opd || (st_r == ST_FINISH && cwr_r);
    stk_wa = push_opd ? IdxW'(cnt_r) : IdxW'(cnt_r - CntW'(2));
    stk_wd = push_opd ? tok_r.value : c_r;
  end

  always_ff @(posedge clk) begin
    if (stk_wr) stk_r[stk_wa] <= stk_wd;
    if (st_r == ST_DISPATCH && tok_r.kind == TOK_OPERATOR && opc_nxt != opc_r)
      ops_r[opc_r[0]] <= tok_r.op;
    // partial products of the 64x64 magnitude product, one level of registers
    if (st_r == ST_MUL_B) begin
      pp_r[0] <= ma_r[31:0]  * mb_r[31:0];
      pp_r[1] <= ma_r[31:0]  * mb_r[63:32];
      pp_r[2] <= ma_r[63:32] * mb_r[31:0];
      pp_r[3] <= ma_r[63:32] * mb_r[63:32];
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt; a_r <= a_nxt; b_r <= b_nxt; rop_r <= rop_nxt;
    neg_r <= neg_nxt; ma_r <= ma_nxt; mb_r <= mb_nxt; prod_r <= prod_nxt;
    num_r <= num_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt; step_r <= step_nxt;
    c_r <= c_nxt; out_val_r <= out_val_nxt; out_err_r <= out_err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; cnt_r <= '0; opc_r <= '0; err_r <= ERR_OK;
      out_vld_r <= 1'b0; cwr_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; opc_r <= opc_nxt; err_r <= err_nxt;
      out_vld_r <= out_vld_nxt; cwr_r <= cwr_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(OPERAND_DEPTH))
    else $error("operand count above depth");
  a_opc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    opc_r <= 2'd2)
    else $error("operator count above two");
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EMIT) |=> out_vld_r)
    else $error("equals did not raise result valid");
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(err_r) != ERR_OK && !($past(st_r) == ST_DISPATCH
      && $past(tok_r.kind) == TOK_CLEAR)) |-> (err_r == $past(err_r)))
    else $error("sticky error changed without clear");

endmodule

[test/infix_expression_evaluator_test.sv]
// self-checking testbench for the infix expression evaluator
// drives token streams on the input bus and checks each result against a
// local predictor of the two-stack evaluator; depends on iee_pkg and the rtl
module infix_expression_evaluator_test
  import iee_pkg::*;
();

  localparam int Depth = int'(DefOperandDepth);
  localparam int Frac  = int'(DefFracBits);
  localparam longint unsigned LimitCycles = 1500000;
  localparam logic [63:0] SatMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SatMin = 64'h8000_0000_0000_0000;

  typedef struct {
    logic [63:0] value;
    err_t        status;
  } calc_result_t;

  class calc_scoreboard;
    logic [63:0]  vals[Depth];
    int           nvals;
    op_t          ops[2];
    int           nops;
    err_t         sticky;
    calc_result_t pending[$];
    int           errors;
    int           checked;

    function void note_error(err_t e);
      if (sticky == ERR_OK) sticky = e;
    endfunction

    function logic [63:0] signed_clip(logic [127:0] mag, bit neg);
      if (neg) begin
        if (mag > {64'd0, SatMin}) begin
          note_error(ERR_SAT);
          return SatMin;
        end
        return -mag[63:0];
      end
      if (mag > {64'd0, SatMax}) begin
        note_error(ERR_SAT);
        return SatMax;
      end
      return mag[63:0];
    endfunction

    function logic [63:0] combine(op_t op, logic [63:0] a, logic [63:0] b);
      logic [63:0]  s;
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic [127:0] wide;
      bit           neg;
      ma  = a[63] ? -a : a;
      mb  = b[63] ? -b : b;
      neg = a[63] ^ b[63];
      case (op)
        OP_ADD, OP_SUB: begin
          s = (op == OP_SUB) ? a - b : a + b;
          if (((op == OP_SUB) ? (a[63] != b[63]) : (a[63] == b[63])) && s[63] != a[63]) begin
            note_error(ERR_SAT);
            return a[63] ? SatMin : SatMax;
          end
          return s;
        end
        OP_MUL: begin
          wide = ({64'd0, ma} * {64'd0, mb}) >> Frac;
          return signed_clip(wide, neg);
        end
        default: begin
          if (b == 0) begin
            note_error(ERR_DIV0);
            return a[63] ? SatMin : SatMax;
          end
          wide = ({64'd0, ma} << Frac) / {64'd0, mb};
          return signed_clip(wide, neg);
        end
      endcase
    endfunction

    function void fold_top();
      op_t op;
      if (nops == 0) return;
      nops--;
      op = ops[nops];
      if (nvals < 2) begin
        note_error(ERR_UNDER);
        return;
      end
      vals[nvals-2] = combine(op, vals[nvals-2], vals[nvals-1]);
      nvals--;
    endfunction

    function void clear_all();
      nvals  = 0;
      nops   = 0;
      sticky = ERR_OK;
    endfunction

    function void note_token(tok_t kind, logic [63:0] value, op_t op);
      calc_result_t r;
      case (kind)
        TOK_OPERAND: begin
          if (nvals >= Depth) note_error(ERR_OVER);
          else begin
            vals[nvals] = value;
            nvals++;
          end
        end
        TOK_OPERATOR: begin
          for (int g = 0; g < 4; g++) begin
            if (nops == 0) break;
            if ((op == OP_MUL || op == OP_DIV) &&
                (ops[nops-1] == OP_ADD || ops[nops-1] == OP_SUB)) break;
            fold_top();
          end
          if (nops >= 2) note_error(ERR_OVER);
          else begin
            ops[nops] = op;
            nops++;
          end
        end
        TOK_EQUALS: begin
          while (nops != 0) fold_top();
          if (nvals == 0) begin
            note_error(ERR_UNDER);
            r.value = '0;
          end else r.value = vals[nvals-1];
          r.status = sticky;
          pending.push_back(r);
        end
        default: clear_all();
      endcase
    endfunction

    function void check_result(logic [63:0] value, logic [2:0] status);
      calc_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result value=%h status=%0d", value, status);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (value !== e.value) begin
        $error("result_value expected %h actual %h", e.value, value);
        errors++;
      end
      if (status !== e.status) begin
        $error("error_status expected %0d actual %0d", e.status, status);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [71:0] out_tdata;

  calc_scoreboard sb;
  longint unsigned cycles = 0;
  int  stall_pct = 0;     // sender idle percentage
  int  hold_cycles = 0;   // long receiver hold-off
  int  sink_pct = 37;
  int  tokens_sent = 0;

  infix_expression_evaluator uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("timeout after %0d cycles", cycles);
      $display("infix_expression_evaluator verification failed");
      $finish;
    end
  end

  // receiver side: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[63:0], out_tdata[66:64]);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready  <= 1'b0;
    end else out_tready <= ($urandom_range(99) >= sink_pct);
  end

  task automatic send_token(tok_t kind, logic [63:0] value, op_t op);
    while (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'd0, op, value};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_token(kind, value, op);
    tokens_sent++;
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(9))
      0: return SatMax;
      1: return SatMin;
      2: return '0;
      3: return {$urandom, $urandom};
      4: return {{32{1'b0}}, 32'd0} + ({32'd0, $urandom_range(20)} << Frac);
      5: return -({32'd0, $urandom_range(20)} << Frac);
      6: return {{24{1'b0}}, 8'($urandom_range(255)), $urandom};
      7: return {{32{1'b1}}, $urandom};
      8: return {2'($urandom_range(3)), 30'd0, $urandom};
      default: return {{30{1'b0}}, 2'b01, $urandom};
    endcase
  endfunction

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // well-formed expression: v op v op v =, with a little noise
  task automatic send_expression();
    int n;
    n = $urandom_range(3);
    if ($urandom_range(3) != 0) send_token(TOK_OPERAND, pick_value(), OP_ADD);
    for (int i = 0; i < n; i++) begin
      send_token(TOK_OPERATOR, pick_value(), op_t'($urandom_range(3)));
      send_token(TOK_OPERAND, pick_value(), OP_ADD);
    end
    if ($urandom_range(9) == 0) send_token(tok_t'($urandom_range(3)), pick_value(),
                                           op_t'($urandom_range(3)));
    send_token(TOK_EQUALS, pick_value(), op_t'($urandom_range(3)));
    if ($urandom_range(3) == 0) send_token(TOK_CLEAR, pick_value(), op_t'($urandom_range(3)));
  endtask

  initial begin
    sb = new();
    sb.clear_all();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every operator, error paths
    send_token(TOK_EQUALS, '0, OP_ADD);                 // empty stack
    send_token(TOK_CLEAR, SatMax, OP_DIV);
    send_token(TOK_OPERAND, SatMax, OP_ADD);
    send_token(TOK_OPERATOR, '0, OP_ADD);
    send_token(TOK_OPERAND, SatMax, OP_ADD);
    send_token(TOK_EQUALS, '0, OP_ADD);                 // saturated sum
    send_token(TOK_CLEAR, '0, OP_ADD);
    send_token(TOK_OPERAND, SatMin, OP_ADD);
    send_token(TOK_OPERATOR, '0, OP_SUB);
    send_token(TOK_OPERAND, 64'd1 << Frac, OP_ADD);
    send_token(TOK_OPERATOR, '0, OP_MUL);
    send_token(TOK_OPERAND, 64'd3 << Frac, OP_ADD);
    send_token(TOK_OPERATOR, '0, OP_DIV);
    send_token(TOK_OPERAND, '0, OP_ADD);                // divide by zero
    send_token(TOK_EQUALS, '0, OP_ADD);
    send_token(TOK_CLEAR, '0, OP_ADD);
    for (int i = 0; i < 5; i++) send_token(TOK_OPERAND, SatMin, OP_ADD); // overflow
    send_token(TOK_OPERATOR, '0, OP_MUL);
    send_token(TOK_EQUALS, '0, OP_ADD);
    send_token(TOK_CLEAR, '0, OP_ADD);
    send_token(TOK_OPERATOR, '0, OP_ADD);               // underflow
    send_token(TOK_EQUALS, '0, OP_ADD);

    stall_pct = 37;
    while (tokens_sent < 500) send_expression();
    // long receiver hold while the sender keeps offering
    hold_cycles = 2000;
    repeat (12) send_expression();
    wait_drained();
    // no idling on either side
    stall_pct = 0;
    sink_pct = 0;
    while (tokens_sent < 900) send_expression();
    stall_pct = 37;
    sink_pct = 37;
    while (tokens_sent < 1470) send_expression();
    wait_drained();

    $display("tokens sent: %0d, results checked: %0d", tokens_sent, sb.checked);
    $display("covered directed extremes, all operators, error cases and random expressions");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("infix_expression_evaluator verification clean");
    else
      $display("infix_expression_evaluator verification failed");
    $finish;
  end
endmodule
